### src/rgb_cross_blur_3x3_assert.svh
// ---------------------------------------------------------------------------
// rgb_cross_blur_3x3 assertion macros
// Short forms for clocked assertions with an active-low asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef RGB_CROSS_BLUR_3X3_ASSERT_SVH
`define RGB_CROSS_BLUR_3X3_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcb assertion failed");

// next-cycle implication, disabled while in reset
`define RCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcb assertion failed");

`endif

### src/rcb_pkg.sv
// ---------------------------------------------------------------------------
// rcb_pkg
// Shared constants, types and arithmetic helpers of the cross blur.
// ---------------------------------------------------------------------------
`default_nettype none

package rcb_pkg;

    // image geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MIN_DIM    = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 9;
    // width used for geometry compares, holds the largest width and column
    localparam int CNT_W      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

    // pixel and channel widths
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int LINE_W     = 2 * PIXEL_W;
    localparam int POS_W      = 8;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = DIM_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam int WIDTH_RESET  = 128;
    localparam int HEIGHT_RESET = 128;

    // result queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    // floor(x/5) for 8-bit x via reciprocal 205/1024
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;
    localparam int DIV5_W     = 6;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // item in the read stage
    typedef struct packed {
        logic             emit;
        logic             frame_done;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        pixel_t           pixel;
    } stage_t;

    // one blurred result
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  column;
        logic              frame_done;
    } result_t;

    function automatic logic [DIV5_W-1:0] div5(input logic [CHAN_W-1:0] x);
        logic [2*CHAN_W-1:0] prod;
        prod = {{CHAN_W{1'b0}}, x} * (2*CHAN_W)'(DIV5_MUL);
        return prod[DIV5_SHIFT +: DIV5_W];
    endfunction

    // clamp a written dimension to MIN_DIM..limit
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int limit);
        logic [CNT_W-1:0] res;
        if (int'(v) < MIN_DIM) begin
            res = CNT_W'(MIN_DIM);
        end
        else if (int'(v) > limit) begin
            res = CNT_W'(limit);
        end
        else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/rcb_ram.sv
// ---------------------------------------------------------------------------
// rcb_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/rgb_cross_blur_3x3.sv
// ---------------------------------------------------------------------------
// rgb_cross_blur_3x3
// Streaming plus-shaped 3x3 blur of a raster-order RGB pixel stream.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while in_ready is high and gives one blurred
// interior pixel per clock while out_ready is high; results pass the read
// stage and queue. Each line of the store RAM holds the pixel of the row
// above and of the row two above for one column; the column is read when
// its pixel is taken and written back the next cycle, so the single write
// and read ports of this RAM set the one pixel per cycle figure. The
// result for centre (r-1,c-1) comes with pixel (r,c); border pixels give
// no result. A three-entry result queue lets input keep flowing while the
// output stalls. The line store has no clearing pass after reset.
`default_nettype none

`include "rgb_cross_blur_3x3_assert.svh"

module rgb_cross_blur_3x3 (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rcb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rcb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel input
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [rcb_pkg::CHAN_W-1:0]        in_red,
    input  wire logic [rcb_pkg::CHAN_W-1:0]        in_green,
    input  wire logic [rcb_pkg::CHAN_W-1:0]        in_blue,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [rcb_pkg::CHAN_W-1:0]        out_red,
    output logic      [rcb_pkg::CHAN_W-1:0]        out_green,
    output logic      [rcb_pkg::CHAN_W-1:0]        out_blue,
    output logic      [rcb_pkg::POS_W-1:0]         out_row,
    output logic      [rcb_pkg::POS_W-1:0]         out_column,
    output logic                                   frame_done
);

    logic [rcb_pkg::CNT_W-1:0]      width_reg;
    logic [rcb_pkg::CNT_W-1:0]      height_reg;
    logic [rcb_pkg::COL_W-1:0]      col_reg;
    logic [rcb_pkg::COL_W-1:0]      col_next;
    logic [rcb_pkg::ROW_W-1:0]      row_reg;
    logic [rcb_pkg::ROW_W-1:0]      row_next;
    logic                           s1_valid_reg;
    rcb_pkg::stage_t                s1_reg;
    rcb_pkg::stage_t                s1_next;
    logic                           in_xfer;
    logic [rcb_pkg::CNT_W-1:0]      c_ext;
    logic [rcb_pkg::CNT_W-1:0]      r_ext;
    logic                           row_end;

    logic [rcb_pkg::LINE_W-1:0]     line_rd;
    logic [rcb_pkg::LINE_W-1:0]     line_wr;
    rcb_pkg::pixel_t                rd_above;
    rcb_pkg::pixel_t                rd_two;
    logic                           line_wr_en;

    rcb_pkg::pixel_t                above_d1_reg;
    rcb_pkg::pixel_t                above_d2_reg;
    rcb_pkg::pixel_t                two_d1_reg;
    rcb_pkg::pixel_t                px_d1_reg;

    rcb_pkg::result_t               res_new;
    rcb_pkg::result_t               fifo_mem [rcb_pkg::FIFO_DEPTH];
    rcb_pkg::result_t               res_head;
    logic [rcb_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [rcb_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [rcb_pkg::FIFO_CNT_W-1:0] fifo_count_reg;
    logic [rcb_pkg::FIFO_CNT_W-1:0] fifo_count_next;
    logic                           push;
    logic                           pop;

    // configuration registers, clamped on write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rcb_pkg::CNT_W'(rcb_pkg::WIDTH_RESET);
            height_reg <= rcb_pkg::CNT_W'(rcb_pkg::HEIGHT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rcb_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= rcb_pkg::clamp_dim(cfg_data, rcb_pkg::MAX_WIDTH);
                end
                rcb_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= rcb_pkg::clamp_dim(cfg_data, rcb_pkg::MAX_HEIGHT);
                end
                default:
                begin
                end
            endcase
        end
    end

    // input acceptance: room in the queue for the item in flight and this one
    assign in_ready = ({1'b0, fifo_count_reg} + {{rcb_pkg::FIFO_CNT_W{1'b0}}, push})
                      < (rcb_pkg::FIFO_CNT_W + 1)'(rcb_pkg::FIFO_DEPTH);
    assign in_xfer  = in_valid && in_ready;

    // raster position and interior test
    always_comb
    begin
        c_ext   = rcb_pkg::CNT_W'(col_reg);
        r_ext   = rcb_pkg::CNT_W'(row_reg);
        row_end = (c_ext >= width_reg - rcb_pkg::CNT_W'(1));

        s1_next.emit       = (r_ext >= rcb_pkg::CNT_W'(2)) && (c_ext >= rcb_pkg::CNT_W'(2))
                             && (c_ext < width_reg) && (r_ext < height_reg);
        s1_next.frame_done = (r_ext == height_reg - rcb_pkg::CNT_W'(1))
                             && (c_ext == width_reg - rcb_pkg::CNT_W'(1));
        s1_next.col        = col_reg;
        s1_next.row        = row_reg;
        s1_next.pixel      = {in_red, in_green, in_blue};

        if (row_end)
        begin
            col_next = '0;
            if (r_ext >= height_reg - rcb_pkg::CNT_W'(1))
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + rcb_pkg::ROW_W'(1);
            end
        end
        else
        begin
            col_next = col_reg + rcb_pkg::COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
            if (in_xfer)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_reg <= s1_next;
        end
    end

    // line store: read column on transfer, write it back the cycle after
    assign rd_above   = line_rd[rcb_pkg::PIXEL_W +: rcb_pkg::PIXEL_W];
    assign rd_two     = line_rd[0 +: rcb_pkg::PIXEL_W];
    assign line_wr    = {s1_reg.pixel, rd_above};
    assign line_wr_en = s1_valid_reg;

    rcb_ram #(
        .WIDTH (rcb_pkg::LINE_W),
        .DEPTH (rcb_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (s1_reg.col),
        .wr_data (line_wr),
        .rd_en   (in_xfer),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    // window of earlier taps along the row
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            above_d1_reg <= rd_above;
            above_d2_reg <= above_d1_reg;
            two_d1_reg   <= rd_two;
            px_d1_reg    <= s1_reg.pixel;
        end
    end

    // five-tap cross sum per channel, each tap divided by five
    function automatic logic [rcb_pkg::CHAN_W-1:0] cross_chan(
        input rcb_pkg::pixel_t t,
        input rcb_pkg::pixel_t l,
        input rcb_pkg::pixel_t m,
        input rcb_pkg::pixel_t r,
        input rcb_pkg::pixel_t b,
        input int              sh
    );
        logic [rcb_pkg::CHAN_W:0] acc;
        acc = (rcb_pkg::CHAN_W + 1)'(rcb_pkg::div5(t[sh +: rcb_pkg::CHAN_W]))
            + (rcb_pkg::CHAN_W + 1)'(rcb_pkg::div5(l[sh +: rcb_pkg::CHAN_W]))
            + (rcb_pkg::CHAN_W + 1)'(rcb_pkg::div5(m[sh +: rcb_pkg::CHAN_W]))
            + (rcb_pkg::CHAN_W + 1)'(rcb_pkg::div5(r[sh +: rcb_pkg::CHAN_W]))
            + (rcb_pkg::CHAN_W + 1)'(rcb_pkg::div5(b[sh +: rcb_pkg::CHAN_W]));
        return acc[rcb_pkg::CHAN_W-1:0];
    endfunction

    always_comb
    begin
        res_new.red        = cross_chan(two_d1_reg, above_d2_reg, above_d1_reg, rd_above,
                                        px_d1_reg, 2 * rcb_pkg::CHAN_W);
        res_new.green      = cross_chan(two_d1_reg, above_d2_reg, above_d1_reg, rd_above,
                                        px_d1_reg, rcb_pkg::CHAN_W);
        res_new.blue       = cross_chan(two_d1_reg, above_d2_reg, above_d1_reg, rd_above,
                                        px_d1_reg, 0);
        res_new.row        = rcb_pkg::POS_W'(s1_reg.row - rcb_pkg::ROW_W'(1));
        res_new.column     = rcb_pkg::POS_W'(s1_reg.col - rcb_pkg::COL_W'(1));
        res_new.frame_done = s1_reg.frame_done;
    end

    // result queue
    assign push = s1_valid_reg && s1_reg.emit;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (push && !pop)
        begin
            fifo_count_next = fifo_count_reg + rcb_pkg::FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fifo_count_next = fifo_count_reg - rcb_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            fifo_count_reg <= fifo_count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == rcb_pkg::FIFO_PTR_W'(rcb_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + rcb_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == rcb_pkg::FIFO_PTR_W'(rcb_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + rcb_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= res_new;
        end
    end

    // output side
    assign res_head   = fifo_mem[rd_ptr_reg];
    assign out_valid  = (fifo_count_reg != '0);
    assign out_red    = res_head.red;
    assign out_green  = res_head.green;
    assign out_blue   = res_head.blue;
    assign out_row    = res_head.row;
    assign out_column = res_head.column;
    assign frame_done = res_head.frame_done;

    // checks
    `RCB_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1,
        fifo_count_reg <= rcb_pkg::FIFO_CNT_W'(rcb_pkg::FIFO_DEPTH))
    `RCB_ASSERT_NOW(a_no_overflow, clk, rst_n, push && !pop,
        fifo_count_reg < rcb_pkg::FIFO_CNT_W'(rcb_pkg::FIFO_DEPTH))
    `RCB_ASSERT_NOW(a_no_addr_clash, clk, rst_n, in_xfer && s1_valid_reg,
        col_reg != s1_reg.col)
    `RCB_ASSERT_NEXT(a_stage_follows, clk, rst_n, in_xfer, s1_valid_reg)
    `RCB_ASSERT_NOW(a_done_is_interior, clk, rst_n, s1_valid_reg && s1_reg.frame_done,
        s1_reg.emit)

endmodule

`default_nettype wire
